// File: hdl/assert_macros.svh
// assertion macros used by the alignment controller core
// expects signals named clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/dhac_pkg.sv
// shared types and constants of the distance and heading alignment controller
// no dependencies
`timescale 1ns / 1ps

package dhac_pkg;

    // in-tolerance readings needed before done, range 1 to 7
    localparam int HOLD_TICKS  = 5;
    localparam int HOLD_W      = 3;
    localparam int ZERO_W      = 3;

    localparam int RANGE_W     = 14;
    localparam int HEADING_W   = 12;
    localparam int TDIST_W     = 9;
    localparam int AXIS_W      = 2;
    localparam int SPEED_W     = 9;
    localparam int TURN_W      = 11;

    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 32;

    // register indexes
    localparam logic [1:0] REG_TARGET_DIST    = 2'd0;
    localparam logic [1:0] REG_AXIS_SELECT    = 2'd1;
    localparam logic [1:0] REG_TARGET_HEADING = 2'd2;

    // axis codes
    localparam logic [1:0] AXIS_FRONT = 2'd0;
    localparam logic [1:0] AXIS_LEFT  = 2'd1;
    localparam logic [1:0] AXIS_RIGHT = 2'd2;

    // linear law
    localparam int TDIST_RESET   = 12;
    localparam int TDIST_LOW     = 10;
    localparam int SPEED_MAX     = 150;
    localparam int SPEED_MIN     = 50;
    localparam int ERR_SAT       = 50;   // 3 * err reaches the clamp here
    localparam int ERR_HOLD      = 30;
    localparam int ERR_DEAD      = 15;
    localparam int ZERO_SAT      = 7;
    localparam int ZERO_LIMIT    = 5;

    // turn law
    localparam int HEADING_HALF  = 1800;
    localparam int HEADING_FULL  = 3600;
    localparam int HEAD_SAT      = 100;  // 7.5 * d reaches the clamp here
    localparam int HEAD_DEAD     = 15;
    localparam int TURN_MAX      = 750;
    localparam int TURN_MIN      = 250;

    typedef struct packed {
        logic [TDIST_W-1:0]   target_distance_cm;
        logic [AXIS_W-1:0]    axis_select;
        logic [HEADING_W-1:0] target_heading_tenths;  // two's complement
    } dhac_cfg_t;

    typedef struct packed {
        logic [HOLD_W-1:0]  hold_count;
        logic [ZERO_W-1:0]  zero_count;
        logic [SPEED_W-1:0] last_speed;  // two's complement
    } dhac_state_t;

    typedef struct packed {
        logic [SPEED_W-1:0] vel_x_mms;
        logic [SPEED_W-1:0] vel_y_mms;
        logic [TURN_W-1:0]  turn_mrads;
        logic               done_res;
    } dhac_res_t;

endpackage

// File: hdl/dhac_law.sv
// control law of one tick: linear speed, turn rate, hold and zero counters
// depends on dhac_pkg
`timescale 1ns / 1ps

module dhac_law
(
    input  dhac_pkg::dhac_cfg_t                 cfg,
    input  dhac_pkg::dhac_state_t               state,
    input  logic [dhac_pkg::RANGE_W-1:0]        range_mm,
    input  logic signed [dhac_pkg::HEADING_W-1:0] heading_tenths,
    output dhac_pkg::dhac_state_t               state_next,
    output dhac_pkg::dhac_res_t                 res
);

    logic [8:0]         tcm_eff;
    logic [12:0]        tmm;
    logic signed [15:0] err;
    logic [14:0]        err_abs;
    logic signed [8:0]  e_small;
    logic signed [8:0]  v_lin;
    logic signed [8:0]  v_clamp;
    logic signed [8:0]  v_floor;
    logic signed [8:0]  v_pick;
    logic signed [8:0]  v_final;
    logic               range_zero;
    logic [2:0]         zc_new;
    logic [2:0]         hold_new;
    logic               done;

    logic signed [12:0] d_raw;
    logic signed [12:0] d_wrap;
    logic [10:0]        d_abs;
    logic [10:0]        prod;
    logic [9:0]         mag;
    logic [10:0]        turn_val;

    // linear speed
    always_comb
    begin
        tcm_eff = (cfg.target_distance_cm < 9'(dhac_pkg::TDIST_LOW))
                  ? 9'(dhac_pkg::TDIST_RESET) : cfg.target_distance_cm;
        tmm     = {1'b0, tcm_eff, 3'b000} + {3'b000, tcm_eff, 1'b0};
        err     = $signed({2'b00, range_mm}) - $signed({3'b000, tmm});
        err_abs = err[15] ? 15'(-err) : err[14:0];
        e_small = err[8:0];
        v_lin   = (e_small <<< 1) + e_small;
        range_zero = (range_mm == '0);

        if (err >= dhac_pkg::ERR_SAT)
            v_clamp = 9'(dhac_pkg::SPEED_MAX);
        else if (err <= -dhac_pkg::ERR_SAT)
            v_clamp = 9'(-dhac_pkg::SPEED_MAX);
        else
            v_clamp = v_lin;

        if (v_clamp >= dhac_pkg::SPEED_MIN || v_clamp <= -dhac_pkg::SPEED_MIN)
            v_floor = v_clamp;
        else if (v_clamp > 0)
            v_floor = 9'(dhac_pkg::SPEED_MIN);
        else
            v_floor = 9'(-dhac_pkg::SPEED_MIN);

        // no reading replays the previous speed
        if (range_zero)
        begin
            v_pick = $signed(state.last_speed);
            zc_new = (state.zero_count == 3'(dhac_pkg::ZERO_SAT))
                     ? state.zero_count : state.zero_count + 3'd1;
        end
        else
        begin
            v_pick = (err_abs < 15'(dhac_pkg::ERR_DEAD)) ? '0 : v_floor;
            zc_new = '0;
        end

        v_final = (zc_new > 3'(dhac_pkg::ZERO_LIMIT)) ? 9'(-dhac_pkg::SPEED_MIN) : v_pick;

        if (err_abs < 15'(dhac_pkg::ERR_HOLD))
            hold_new = state.hold_count + 3'd1;
        else if (!range_zero)
            hold_new = '0;
        else
            hold_new = state.hold_count;

        done = (hold_new >= 3'(dhac_pkg::HOLD_TICKS));

        state_next.hold_count = done ? '0 : hold_new;
        state_next.zero_count = done ? '0 : zc_new;
        state_next.last_speed = v_final;
    end

    // axis routing
    always_comb
    begin
        res.vel_x_mms = '0;
        res.vel_y_mms = '0;
        case (cfg.axis_select)
            dhac_pkg::AXIS_FRONT: res.vel_x_mms = v_final;
            dhac_pkg::AXIS_LEFT:  res.vel_y_mms = v_final;
            dhac_pkg::AXIS_RIGHT: res.vel_y_mms = -v_final;
            default:
            begin
                res.vel_x_mms = '0;
                res.vel_y_mms = '0;
            end
        endcase
        res.turn_mrads = turn_val;
        res.done_res = done;
    end

    // turn rate, heading error wrapped once
    always_comb
    begin
        d_raw = $signed({cfg.target_heading_tenths[11], cfg.target_heading_tenths})
              - $signed({heading_tenths[11], heading_tenths});
        if (d_raw < -dhac_pkg::HEADING_HALF)
            d_wrap = d_raw + 13'(dhac_pkg::HEADING_FULL);
        else if (d_raw > dhac_pkg::HEADING_HALF)
            d_wrap = d_raw - 13'(dhac_pkg::HEADING_FULL);
        else
            d_wrap = d_raw;

        d_abs = d_wrap[12] ? 11'(-d_wrap) : d_wrap[10:0];
        // 15 * |d| for |d| below the clamp point
        prod  = {d_abs[6:0], 4'b0000} - {4'b0000, d_abs[6:0]};

        if (d_abs >= 11'(dhac_pkg::HEAD_SAT))
            mag = 10'(dhac_pkg::TURN_MAX);
        else
            mag = prod[10:1];
        if (mag < 10'(dhac_pkg::TURN_MIN))
            mag = 10'(dhac_pkg::TURN_MIN);
        if (d_abs < 11'(dhac_pkg::HEAD_DEAD))
            mag = '0;

        turn_val = d_wrap[12] ? -{1'b0, mag} : {1'b0, mag};
    end

endmodule

// File: hdl/distance_heading_align_controller_core.sv
// top level of the distance and heading alignment controller
// depends on dhac_pkg, dhac_law and assert_macros.svh
`timescale 1ns / 1ps

// One request per control tick: range in mm and heading in tenths of a degree in,
// velocity commands, turn rate and a done flag out. A new request is taken every
// clock cycle unless the output stalls; each result passes through the input
// register, then the law logic into the result register. The controller state (hold
// count, zero-reading count, last speed) is updated as each request moves from the
// input register to the result register, so results follow requests strictly in
// order. Configuration writes take effect at once; users must make them while idle (unchecked).
`include "assert_macros.svh"

module distance_heading_align_controller_core
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [11:0] cfg_wdata,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [13:0] range_mm, [25:14] heading_tenths, rest zero

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [8:0] vel_x_mms, [17:9] vel_y_mms,
                                   // [28:18] turn_mrads, [29] done_res, rest zero
);

    dhac_pkg::dhac_cfg_t   cfg_reg;
    dhac_pkg::dhac_state_t state_reg;
    dhac_pkg::dhac_state_t state_next;
    dhac_pkg::dhac_res_t   law_res;
    dhac_pkg::dhac_res_t   out_reg;

    logic                                 stage_valid_reg;
    logic [dhac_pkg::RANGE_W-1:0]         stage_range_reg;
    logic signed [dhac_pkg::HEADING_W-1:0] stage_heading_reg;
    logic                                 out_valid_reg;
    logic                                 advance;
    logic                                 accept;

    assign advance  = stage_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !stage_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_distance_cm    <= 9'(dhac_pkg::TDIST_RESET);
            cfg_reg.axis_select           <= dhac_pkg::AXIS_FRONT;
            cfg_reg.target_heading_tenths <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                dhac_pkg::REG_TARGET_DIST:
                    cfg_reg.target_distance_cm <= cfg_wdata[8:0];
                dhac_pkg::REG_AXIS_SELECT:
                    cfg_reg.axis_select <= cfg_wdata[1:0];
                dhac_pkg::REG_TARGET_HEADING:
                    cfg_reg.target_heading_tenths <= cfg_wdata;
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // control state and valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= '0;
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (advance)
                state_reg <= state_next;
            if (s_tready)
                stage_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_range_reg   <= s_tdata[13:0];
            stage_heading_reg <= s_tdata[25:14];
        end
        if (advance)
            out_reg <= law_res;
    end

    dhac_law u_law
    (
        .cfg            (cfg_reg),
        .state          (state_reg),
        .range_mm       (stage_range_reg),
        .heading_tenths (stage_heading_reg),
        .state_next     (state_next),
        .res            (law_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.done_res, out_reg.turn_mrads,
                       out_reg.vel_y_mms, out_reg.vel_x_mms};

    `ASSERT_CLK(a_hold_below_limit,
        state_reg.hold_count < 3'(dhac_pkg::HOLD_TICKS),
        "hold count reached limit without clearing")
    `ASSERT_CLK(a_done_clears,
        advance && law_res.done_res |=>
            state_reg.hold_count == 3'd0 && state_reg.zero_count == 3'd0,
        "counters not cleared after done")
    `ASSERT_CLK(a_zero_run_backs_off,
        advance && stage_range_reg == '0
            && state_reg.zero_count >= 3'(dhac_pkg::ZERO_LIMIT) |=>
            $signed(state_reg.last_speed) == -dhac_pkg::SPEED_MIN,
        "long zero run did not force back-off speed")

endmodule

// File: test/distance_heading_align_controller_core_tb.sv
// self-checking testbench for distance_heading_align_controller_core
// drives range/heading ticks on the stream ports, checks each command against predictor or typed row
// depends on dhac_pkg and the core rtl
`timescale 1ns / 1ps

module distance_heading_align_controller_core_tb;

    // axis code that drives neither linear field
    localparam logic [1:0] AXIS_NONE = 2'd3;

    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_TICKS   = 135;
    localparam int N_DIR         = 24;
    localparam int N_SET         = 8;
    localparam int MAX_REPORTS   = 40;

    typedef struct {
        int rng;
        int hdg;
        bit typed;
        int vx;
        int vy;
        int w;
        bit done;
    } dir_tick_t;

    typedef struct {
        int dist_cm;
        int axis;
        int head;
    } reg_set_t;

    // rows after reset: 120 mm target, front axis, heading 0
    dir_tick_t dir_ticks [N_DIR] = '{
        '{  120,     0, 1,    0, 0,    0, 0},   // on target, all dead zones
        '{16383, -1800, 1,  150, 0,  750, 0},   // both clamps positive
        '{    0,  1800, 1,  150, 0, -750, 0},   // zero reading replays last speed
        '{    0, -2048, 0,    0, 0,    0, 0},   // out-of-range heading wraps once
        '{    0,  2047, 0,    0, 0,    0, 0},
        '{    0,    14, 0,    0, 0,    0, 0},   // just inside heading dead zone
        '{    0,   -15, 0,    0, 0,    0, 0},   // heading error 15, floor at 250
        '{    0,    15, 0,    0, 0,    0, 0},   // sixth zero reading forces -50
        '{    0,    33, 0,    0, 0,    0, 0},
        '{    0,   -35, 0,    0, 0,    0, 0},   // zero count saturated
        '{    1,  -100, 0,    0, 0,    0, 0},   // negative clamp, turn at clamp edge
        '{  121,    99, 0,    0, 0,    0, 0},
        '{  135,     1, 0,    0, 0,    0, 0},   // error 15, speed floor
        '{  105,    -1, 0,    0, 0,    0, 0},
        '{  149,  1800, 0,    0, 0,    0, 0},   // error 29 still in tolerance
        '{   90, -1800, 0,    0, 0,    0, 0},   // error -30 clears hold count
        '{  134,    34, 0,    0, 0,    0, 0},
        '{  106,     0, 0,    0, 0,    0, 0},
        '{  120,     0, 0,    0, 0,    0, 0},
        '{  120,     0, 0,    0, 0,    0, 0},
        '{  120,     0, 1,    0, 0,    0, 1},   // fifth in-tolerance reading
        '{  137,     0, 0,    0, 0,    0, 0},
        '{    0,     0, 0,    0, 0,    0, 0},   // replays a small speed
        '{  120,     0, 0,    0, 0,    0, 0}
    };

    reg_set_t reg_sets [N_SET] = '{
        '{ 12, dhac_pkg::AXIS_FRONT,     0},
        '{  0, dhac_pkg::AXIS_LEFT,  -1800},
        '{511, dhac_pkg::AXIS_RIGHT,  1800},
        '{  9, AXIS_NONE,             2047},
        '{ 10, dhac_pkg::AXIS_FRONT, -2048},
        '{500, dhac_pkg::AXIS_LEFT,    900},
        '{250, dhac_pkg::AXIS_RIGHT,  -450},
        '{ 37, dhac_pkg::AXIS_FRONT,     1}
    };

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr  = '0;
    logic [11:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;

    // predictor copy of registers and controller state
    int                 cfg_dist = dhac_pkg::TDIST_RESET;
    logic [1:0]         cfg_axis = dhac_pkg::AXIS_FRONT;
    logic signed [11:0] cfg_head = '0;
    int                 hold_cnt = 0;
    int                 zero_cnt = 0;
    int                 last_spd = 0;

    dhac_pkg::dhac_res_t pending_cmds [$];

    int src_idle_pct  = 37;
    int sink_idle_pct = 50;
    int zero_burst    = 0;
    int near_burst    = 0;
    int n_ticks       = 0;
    int n_done        = 0;
    int n_errors      = 0;
    int stall_cycles  = 0;

    distance_heading_align_controller_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int mag(int x);
        return (x < 0) ? -x : x;
    endfunction

    // one control tick of the alignment law, updates the predictor state
    function automatic dhac_pkg::dhac_res_t align_law(logic [13:0] rng,
                                                      logic signed [11:0] hdg);
        int                  tcm;
        int                  e;
        int                  v;
        int                  d;
        int                  w;
        dhac_pkg::dhac_res_t r;
        tcm = (cfg_dist < dhac_pkg::TDIST_LOW) ? dhac_pkg::TDIST_RESET : cfg_dist;
        e = int'(rng) - tcm * 10;
        v = 3 * e;
        if (v > dhac_pkg::SPEED_MAX) v = dhac_pkg::SPEED_MAX;
        if (v < -dhac_pkg::SPEED_MAX) v = -dhac_pkg::SPEED_MAX;
        if (mag(v) < dhac_pkg::SPEED_MIN) v = (v > 0) ? dhac_pkg::SPEED_MIN : -dhac_pkg::SPEED_MIN;
        if (mag(e) < dhac_pkg::ERR_HOLD) hold_cnt++;
        else if (rng != 0) hold_cnt = 0;
        if (mag(e) < dhac_pkg::ERR_DEAD && rng != 0) v = 0;
        if (rng == 0)
        begin
            v = last_spd;
            if (zero_cnt < dhac_pkg::ZERO_SAT) zero_cnt++;
        end
        else
        begin
            zero_cnt = 0;
        end
        if (zero_cnt > dhac_pkg::ZERO_LIMIT) v = -dhac_pkg::SPEED_MIN;
        last_spd = v;

        r = '0;
        case (cfg_axis)
            dhac_pkg::AXIS_FRONT: r.vel_x_mms = 9'(v);
            dhac_pkg::AXIS_LEFT:  r.vel_y_mms = 9'(v);
            dhac_pkg::AXIS_RIGHT: r.vel_y_mms = 9'(-v);
            default: ;
        endcase

        d = int'(cfg_head) - int'(hdg);
        if (d < -dhac_pkg::HEADING_HALF) d += dhac_pkg::HEADING_FULL;
        else if (d > dhac_pkg::HEADING_HALF) d -= dhac_pkg::HEADING_FULL;
        w = (mag(d) * 15) / 2;
        if (d < 0) w = -w;
        if (w > dhac_pkg::TURN_MAX) w = dhac_pkg::TURN_MAX;
        if (w < -dhac_pkg::TURN_MAX) w = -dhac_pkg::TURN_MAX;
        if (mag(w) < dhac_pkg::TURN_MIN) w = (w > 0) ? dhac_pkg::TURN_MIN : -dhac_pkg::TURN_MIN;
        if (mag(d) < dhac_pkg::HEAD_DEAD) w = 0;
        r.turn_mrads = 11'(w);

        if (hold_cnt >= dhac_pkg::HOLD_TICKS)
        begin
            r.done_res = 1'b1;
            hold_cnt = 0;
            zero_cnt = 0;
        end
        return r;
    endfunction

    // mostly in-tolerance approach runs and zero-reading runs, the rest spread wide
    function automatic logic [13:0] pick_range(int tmm);
        int r;
        int sel;
        if (zero_burst > 0)
        begin
            zero_burst--;
            return '0;
        end
        if (near_burst > 0)
        begin
            near_burst--;
            if ($urandom_range(0, 9) == 0) return '0;
            r = tmm + int'($urandom_range(0, 58)) - 29;
        end
        else
        begin
            sel = $urandom_range(0, 99);
            if (sel < 10)
            begin
                zero_burst = $urandom_range(0, 7);
                return '0;
            end
            else if (sel < 40)
            begin
                near_burst = $urandom_range(3, 7);
                r = tmm + int'($urandom_range(0, 58)) - 29;
            end
            else if (sel < 75)
                r = tmm + int'($urandom_range(0, 240)) - 120;
            else
                r = $urandom_range(0, 16383);
        end
        if (r < 0) r = 0;
        if (r > 16383) r = 16383;
        return 14'(r);
    endfunction

    function automatic logic [11:0] pick_heading(int head);
        int h;
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 50)
            h = head + int'($urandom_range(0, 240)) - 120;
        else if (sel < 80)
            h = int'($urandom_range(0, 3600)) - 1800;
        else
            h = int'($urandom_range(0, 4095)) - 2048;
        if (h < -2048) h = -2048;
        if (h > 2047) h = 2047;
        return 12'(h);
    endfunction

    task automatic send_tick(logic [13:0] rng, logic [11:0] hdg, bit typed,
                             dhac_pkg::dhac_res_t typed_res);
        dhac_pkg::dhac_res_t pred;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, hdg, rng};
        do
            @(posedge clk);
        while (!s_tready);
        pred = align_law(rng, hdg);
        pending_cmds.push_back(typed ? typed_res : pred);
        n_ticks++;
    endtask

    task automatic drain_cmds();
        s_tvalid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= 12'(val);
        @(posedge clk);
        case (idx)
            dhac_pkg::REG_TARGET_DIST:    cfg_dist = val & 'h1FF;
            dhac_pkg::REG_AXIS_SELECT:    cfg_axis = 2'(val);
            dhac_pkg::REG_TARGET_HEADING: cfg_head = 12'(val);
            default: ;
        endcase
    endtask

    task automatic cmp_field(string nm, int expv, int actv);
        if (expv != actv)
        begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, nm, expv, actv);
        end
    endtask

    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);

    always @(posedge clk)
    begin
        dhac_pkg::dhac_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_cmds.size() == 0)
            begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("%0t: result with no request pending, expected none, actual %h",
                             $time, m_tdata);
            end
            else
            begin
                want = pending_cmds.pop_front();
                if (want.done_res) n_done++;
                cmp_field("vel_x_mms", int'($signed(want.vel_x_mms)),
                          int'($signed(m_tdata[8:0])));
                cmp_field("vel_y_mms", int'($signed(want.vel_y_mms)),
                          int'($signed(m_tdata[17:9])));
                cmp_field("turn_mrads", int'($signed(want.turn_mrads)),
                          int'($signed(m_tdata[28:18])));
                cmp_field("done_res", int'(want.done_res), int'(m_tdata[29]));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        dhac_pkg::dhac_res_t row_res;
        int                  tmm;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed ticks on reset register values
        for (int i = 0; i < N_DIR; i++)
        begin
            row_res            = '0;
            row_res.vel_x_mms  = 9'(dir_ticks[i].vx);
            row_res.vel_y_mms  = 9'(dir_ticks[i].vy);
            row_res.turn_mrads = 11'(dir_ticks[i].w);
            row_res.done_res   = dir_ticks[i].done;
            send_tick(14'(dir_ticks[i].rng), 12'(dir_ticks[i].hdg), dir_ticks[i].typed, row_res);
        end

        for (int p = 0; p < N_SET; p++)
        begin
            drain_cmds();
            write_reg(dhac_pkg::REG_TARGET_DIST, reg_sets[p].dist_cm);
            write_reg(dhac_pkg::REG_AXIS_SELECT, reg_sets[p].axis);
            write_reg(dhac_pkg::REG_TARGET_HEADING, reg_sets[p].head);
            cfg_wr_en <= 1'b0;
            if (p < 3)
            begin
                src_idle_pct  = 37;
                sink_idle_pct = 50;
            end
            else if (p < 6)
            begin
                src_idle_pct  = 50;
                sink_idle_pct = 37;
            end
            else
            begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            zero_burst = 0;
            near_burst = 0;
            tmm = ((cfg_dist < dhac_pkg::TDIST_LOW) ? dhac_pkg::TDIST_RESET : cfg_dist) * 10;
            for (int i = 0; i < PHASE_TICKS; i++)
            begin
                send_tick(pick_range(tmm), pick_heading(int'(cfg_head)), 1'b0, '0);
                // hold off mid-run until the pipeline is empty
                if (p == 1 && i == 60) drain_cmds();
            end
        end

        drain_cmds();
        repeat (8) @(posedge clk);

        $display("ran %0d control ticks over reset values and %0d register settings", n_ticks,
                 N_SET);
        $display("saw %0d done pulses, zero-reading runs, all axis codes and heading wraps",
                 n_done);
        if (n_errors == 0 && pending_cmds.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/dhac_pkg.sv
hdl/dhac_law.sv
hdl/distance_heading_align_controller_core.sv
test/distance_heading_align_controller_core_tb.sv
